/* hw/rtl/udr_pkg.sv */
package udr_pkg;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic valid;  // stage holds an item
    logic neg;    // quotient needs negation at the end
    logic dbz;    // divisor was zero
  } udr_ctl_t;

endpackage

/* hw/rtl/udr_prep.sv */
// Front stage: zero-divisor check and dividend magnitude.
module udr_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic                  signed_dividend,
  output udr_pkg::udr_ctl_t     ctl_r,
  output logic [DATA_WIDTH-1:0] num_r,
  output logic [DATA_WIDTH-1:0] den_r
);

  udr_pkg::udr_ctl_t     ctl_nxt;
  logic [DATA_WIDTH-1:0] num_nxt;

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.dbz   = (divisor == '0);
    // zero divisor keeps the raw dividend so it falls out as the remainder
    ctl_nxt.neg   = signed_dividend & dividend[DATA_WIDTH-1] & ~ctl_nxt.dbz;
    num_nxt       = ctl_nxt.neg ? (DATA_WIDTH'(0) - dividend) : dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= divisor;
    end
  end

endmodule

/* hw/rtl/udr_step.sv */
// One restoring step: shift in the next dividend bit, trial subtract,
// shift the quotient bit into the low end of the dividend register.
module udr_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  udr_pkg::udr_ctl_t     ctl_i,
  input  logic [DATA_WIDTH-1:0] part_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  output udr_pkg::udr_ctl_t     ctl_r,
  output logic [DATA_WIDTH-1:0] part_r,
  output logic [DATA_WIDTH-1:0] num_r,
  output logic [DATA_WIDTH-1:0] den_r
);

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] part_nxt;
  logic [DATA_WIDTH-1:0] num_nxt;

  always_comb begin
    trial    = {part_i, num_i[DATA_WIDTH-1]};
    diff     = trial - {1'b0, den_i};
    qbit     = ~diff[DATA_WIDTH];
    part_nxt = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    num_nxt  = {num_i[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
      num_r  <= num_nxt;
      den_r  <= den_i;
    end
  end

endmodule

/* hw/rtl/udr_fix.sv */
// Back stage: quotient sign fixup, zero-divisor override, output register.
module udr_fix #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  udr_pkg::udr_ctl_t     ctl_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  output logic                  valid_r,
  output logic [DATA_WIDTH-1:0] quo_r,
  output logic [DATA_WIDTH-1:0] rem_r,
  output logic                  dbz_r
);

  logic [DATA_WIDTH-1:0] quo_nxt;

  always_comb begin
    if (ctl_i.dbz) begin
      quo_nxt = '0;
    end else if (ctl_i.neg) begin
      quo_nxt = DATA_WIDTH'(0) - quo_i;
    end else begin
      quo_nxt = quo_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      rem_r <= rem_i;
      dbz_r <= ctl_i.dbz;
    end
  end

endmodule

/* hw/rtl/unsigned_divide_with_remainder_core.sv */
// Pipelined restoring divider. Each input transfer carries a dividend and an
// unsigned divisor; a set signed flag treats the dividend as two's complement.
// The result is the truncating quotient (negated for a negative dividend) and
// the remainder of the magnitudes. A zero divisor raises divide_by_zero with
// quotient 0 and the dividend returned unchanged as the remainder.
// Stages: one front stage, one subtract stage per quotient bit, one output
// stage. A new transfer is taken every cycle; the whole pipe stalls only
// while the output holds a result that is not taken.
module unsigned_divide_with_remainder_core #(
  parameter  int DATA_WIDTH = 32,
  localparam int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // dividend, divisor, zero pad
  input  logic               in_tuser,   // signed_dividend
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // quotient, remainder, zero pad
  output logic               out_tuser   // divide_by_zero
);

  localparam int W = DATA_WIDTH;

  // single pipe-wide enable: everything moves unless the output is blocked
  logic en;

  udr_pkg::udr_ctl_t ctl_s  [0:W];
  logic [W-1:0]      part_s [0:W];
  logic [W-1:0]      num_s  [0:W];
  logic [W-1:0]      den_s  [0:W];

  logic [W-1:0]      quo_r;
  logic [W-1:0]      rem_r;
  logic              dbz_r;

  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  udr_prep #(.DATA_WIDTH(W)) u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_tvalid),
    .dividend        (in_tdata[W-1:0]),
    .divisor         (in_tdata[2*W-1:W]),
    .signed_dividend (in_tuser),
    .ctl_r           (ctl_s[0]),
    .num_r           (num_s[0]),
    .den_r           (den_s[0])
  );

  // partial remainder starts empty
  assign part_s[0] = '0;

  // one stage per quotient bit, MSB first
  for (genvar i = 0; i < W; i++) begin : g_step
    udr_step #(.DATA_WIDTH(W)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[i]),
      .part_i (part_s[i]),
      .num_i  (num_s[i]),
      .den_i  (den_s[i]),
      .ctl_r  (ctl_s[i+1]),
      .part_r (part_s[i+1]),
      .num_r  (num_s[i+1]),
      .den_r  (den_s[i+1])
    );
  end

  // after the last step num holds the quotient, part the remainder;
  // den of the last stage is not needed
  udr_fix #(.DATA_WIDTH(W)) u_fix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_s[W]),
    .quo_i   (num_s[W]),
    .rem_i   (part_s[W]),
    .valid_r (out_tvalid),
    .quo_r   (quo_r),
    .rem_r   (rem_r),
    .dbz_r   (dbz_r)
  );

  assign out_tdata = TDATA_W'({rem_r, quo_r});
  assign out_tuser = dbz_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // zero-divisor result always carries a zero quotient
  a_dbz_quo_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[W-1:0] == '0)
    else $error("divide-by-zero result with nonzero quotient");

  // pipe stalls only when the output holds an untaken result
  a_ready_rule : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // reset empties the output register
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // no result shows up at the output just after reset is released
  a_no_early_valid : assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_tvalid)
    else $error("result valid one cycle after reset release");

  // stage valid bits follow the enable: front and last step control hold while stalled
  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_s[0]) && $stable(ctl_s[W]))
    else $error("pipeline control moved during stall");

endmodule
